// File: sv/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk outside reset
`define HBSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge of clk, reset included
`define HBSW_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hbsw_pkg.sv
package hbsw_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUNNING_CODE  = 2'd3;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd50;
  localparam logic [15:0] STALL_TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  STRIKE_LIMIT_RST  = 8'd3;
  localparam logic [7:0]  RUNNING_CODE_RST  = 8'd2;

  localparam logic [7:0]  STRIKE_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] poll_interval;
    logic [15:0] stall_timeout;
    logic [7:0]  strike_limit;
    logic [7:0]  running_code;
  } cfg_t;

  typedef struct packed {
    logic        safe_active;
    logic        tripped_now;
    logic [31:0] trips_total;
    logic [7:0]  strikes;
    logic [31:0] last_trip_at;
    logic [31:0] uptime;
    logic [31:0] own_beats;
    logic [7:0]  fault_code;
  } result_t;

endpackage

// File: sv/hbsw_cfg.sv
module hbsw_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [hbsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output hbsw_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval <= hbsw_pkg::POLL_INTERVAL_RST;
      cfg.stall_timeout <= hbsw_pkg::STALL_TIMEOUT_RST;
      cfg.strike_limit  <= hbsw_pkg::STRIKE_LIMIT_RST;
      cfg.running_code  <= hbsw_pkg::RUNNING_CODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        hbsw_pkg::REG_POLL_INTERVAL: cfg.poll_interval <= cfg_data;
        hbsw_pkg::REG_STALL_TIMEOUT: cfg.stall_timeout <= cfg_data;
        hbsw_pkg::REG_STRIKE_LIMIT:  cfg.strike_limit  <= cfg_data[7:0];
        hbsw_pkg::REG_RUNNING_CODE:  cfg.running_code  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/hbsw_tracker.sv
module hbsw_tracker (
  input  logic                clk,
  input  logic                rst,
  input  hbsw_pkg::cfg_t      cfg,
  input  logic                fire,
  input  logic [31:0]         count,
  input  logic [7:0]          state_code,
  output hbsw_pkg::result_t   res
);

  logic        baseline_taken, baseline_taken_next;
  logic [31:0] last_count, last_count_next;
  logic [16:0] stall_time, stall_time_next;
  logic [31:0] uptime_reg, uptime_reg_next;
  logic [31:0] beat_reg, beat_reg_next;
  logic        safe_flag, safe_flag_next;
  logic [31:0] trip_total_reg, trip_total_reg_next;
  logic [7:0]  strike_reg, strike_reg_next;
  logic [31:0] trip_time_reg, trip_time_reg_next;
  logic [7:0]  fault_reg, fault_reg_next;

  logic        healthy;
  logic        active;
  logic [16:0] stall_sum;
  logic        tripped;

  assign healthy   = (state_code == cfg.running_code) && (count != last_count);
  assign active    = state_code >= cfg.running_code;
  assign stall_sum = stall_time + {1'b0, cfg.poll_interval};

  always_comb begin
    baseline_taken_next = baseline_taken;
    last_count_next     = last_count;
    stall_time_next     = stall_time;
    uptime_reg_next     = uptime_reg;
    beat_reg_next       = beat_reg;
    safe_flag_next      = safe_flag;
    trip_total_reg_next = trip_total_reg;
    strike_reg_next     = strike_reg;
    trip_time_reg_next  = trip_time_reg;
    fault_reg_next      = fault_reg;
    tripped             = 1'b0;

    if (!baseline_taken) begin
      baseline_taken_next = 1'b1;
      last_count_next     = count;
    end else begin
      uptime_reg_next = uptime_reg + {16'd0, cfg.poll_interval};
      beat_reg_next   = beat_reg + 32'd1;
      if (healthy) begin
        last_count_next = count;
        stall_time_next = '0;
        if (safe_flag && (strike_reg < cfg.strike_limit)) begin
          safe_flag_next  = 1'b0;
          strike_reg_next = '0;
        end
      end else if (active) begin
        stall_time_next = stall_sum;
        if (stall_sum >= {1'b0, cfg.stall_timeout}) begin
          tripped             = 1'b1;
          trip_total_reg_next = trip_total_reg + 32'd1;
          if (strike_reg != hbsw_pkg::STRIKE_MAX) begin
            strike_reg_next = strike_reg + 8'd1;
          end
          // trip time takes the uptime already advanced on this tick
          trip_time_reg_next = uptime_reg_next;
          fault_reg_next     = state_code;
          safe_flag_next     = 1'b1;
          stall_time_next    = '0;
          last_count_next    = count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_taken <= 1'b0;
      last_count     <= '0;
      stall_time     <= '0;
      uptime_reg     <= '0;
      beat_reg       <= '0;
      safe_flag      <= 1'b0;
      trip_total_reg <= '0;
      strike_reg     <= '0;
      trip_time_reg  <= '0;
      fault_reg      <= '0;
    end else if (fire) begin
      baseline_taken <= baseline_taken_next;
      last_count     <= last_count_next;
      stall_time     <= stall_time_next;
      uptime_reg     <= uptime_reg_next;
      beat_reg       <= beat_reg_next;
      safe_flag      <= safe_flag_next;
      trip_total_reg <= trip_total_reg_next;
      strike_reg     <= strike_reg_next;
      trip_time_reg  <= trip_time_reg_next;
      fault_reg      <= fault_reg_next;
    end
  end

  always_comb begin
    res.safe_active  = safe_flag_next;
    res.tripped_now  = tripped;
    res.trips_total  = trip_total_reg_next;
    res.strikes      = strike_reg_next;
    res.last_trip_at = trip_time_reg_next;
    res.uptime       = uptime_reg_next;
    res.own_beats    = beat_reg_next;
    res.fault_code   = fault_reg_next;
  end

endmodule

// File: sv/heartbeat_stall_watchdog_top.sv
// heartbeat stall watchdog
// tick channel: tick_valid / tick_stall carry one poll transaction (seen_count,
// seen_state); a transaction is taken at an edge with tick_valid high and
// tick_stall low.
// result channel: result_valid / result_stall carry one result transaction per
// tick, the status fields after that tick was judged.
// config: cfg_write with cfg_index / cfg_data writes poll_interval (0),
// stall_timeout (1), strike_limit (2) or running_code (3); write only while idle.
// stages: a taken tick passes two register stages: the input register, then the
// result register.
// throughput: one tick per clock cycle unless the receiver stalls; the update
// is a single pass of compares and adds between the input and result registers.
// receiver stall: the result register holds its transaction, the input register
// keeps one more tick, and tick_stall rises while that tick cannot move on.
// reset (rst, synchronous): both stages empty, config back to its defaults,
// all watchdog state cleared; the first tick after reset only takes a baseline.
module heartbeat_stall_watchdog_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [hbsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             tick_valid,
  output logic                             tick_stall,
  input  logic [31:0]                      seen_count,
  input  logic [7:0]                       seen_state,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             safe_active,
  output logic                             tripped_now,
  output logic [31:0]                      trips_total,
  output logic [7:0]                       strikes,
  output logic [31:0]                      last_trip_at,
  output logic [31:0]                      uptime,
  output logic [31:0]                      own_beats,
  output logic [7:0]                       fault_code
);

  hbsw_pkg::cfg_t    cfg;
  hbsw_pkg::result_t res;

  logic        in_valid;
  logic [31:0] in_count;
  logic [7:0]  in_state;
  logic        advance;
  logic        fire;
  logic        take;

  assign advance    = !result_valid || !result_stall;
  assign fire       = in_valid && advance;
  assign tick_stall = in_valid && !advance;
  assign take       = tick_valid && !tick_stall;

  hbsw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hbsw_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .count      (in_count),
    .state_code (in_state),
    .res        (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_count <= seen_count;
      in_state <= seen_state;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      safe_active  <= res.safe_active;
      tripped_now  <= res.tripped_now;
      trips_total  <= res.trips_total;
      strikes      <= res.strikes;
      last_trip_at <= res.last_trip_at;
      uptime       <= res.uptime;
      own_beats    <= res.own_beats;
      fault_code   <= res.fault_code;
    end
  end

endmodule

// File: sv/hbsw_checker.sv
`include "assert_macros.svh"

module hbsw_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        safe_active,
  input logic        tripped_now,
  input logic [7:0]  strikes,
  input logic [31:0] last_trip_at,
  input logic [31:0] uptime
);

  logic shown_trip;
  logic out_held;

  assign shown_trip = result_valid && tripped_now;
  assign out_held   = result_valid && result_stall;

  // a trip always latches safe state in the same result
  `HBSW_ASSERT(trip_sets_safe, shown_trip |-> safe_active, "trip without safe state")

  // the recorded trip time is the uptime of the tripping tick
  `HBSW_ASSERT(trip_time_match, shown_trip |-> last_trip_at == uptime, "trip time not uptime")

  // a trip leaves at least one strike
  `HBSW_ASSERT(trip_has_strike, shown_trip |-> strikes != 8'd0, "trip with zero strikes")

  // a stalled result transaction stays put
  `HBSW_ASSERT(stall_holds, out_held |=> result_valid && $stable(uptime), "stalled result moved")

  // reset empties the result register
  `HBSW_ASSERT_ALL(reset_empties, rst |=> !result_valid, "result valid after reset")

endmodule

bind heartbeat_stall_watchdog_top hbsw_checker u_hbsw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .safe_active  (safe_active),
  .tripped_now  (tripped_now),
  .strikes      (strikes),
  .last_trip_at (last_trip_at),
  .uptime       (uptime)
);
